/* rtl/rtcc_pkg.sv */
// Package for the RTC calendar tick core: the calendar state type,
// operation codes, event flag positions, constant tables and small helpers.
// No dependencies.
package rtcc_pkg;

  // Operation codes carried by an input item
  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_SET_TIME = 2'd1,
    OP_SET_DATE = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  // Periodic check rates, in seconds
  localparam int unsigned SENSOR_RATE = 2;
  localparam int unsigned BATT_RATE   = 30;

  // Event flag bit positions
  localparam int unsigned FLG_SENSOR  = 0;
  localparam int unsigned FLG_BATTERY = 1;
  localparam int unsigned FLG_MINUTE  = 2;
  localparam int unsigned FLG_CFGSAVE = 3;
  localparam int unsigned FLG_HOUR    = 4;
  localparam int unsigned FLG_CLEAR   = 5;
  localparam int unsigned FLG_DAY     = 6;
  localparam int unsigned FLG_WDOG    = 7;

  // Calendar limits
  localparam logic [8:0] SEC_PER_MIN  = 9'd60;
  localparam logic [8:0] MIN_PER_HOUR = 9'd60;
  localparam logic [8:0] HOUR_PER_DAY = 9'd24;
  localparam logic [8:0] CLEAR_HOUR   = 9'd20;
  localparam int unsigned SAVE_MINUTES = 15;
  localparam logic [7:0] LAST_MONTH   = 8'd12;
  localparam logic [7:0] LAST_YEAR    = 8'd99;
  localparam logic [2:0] LAST_WEEKDAY = 3'd6;

  // Range limits on raw BCD bytes of set items
  localparam logic [7:0] BCD_HOUR_MAX  = 8'h23;
  localparam logic [7:0] BCD_MINSEC_MAX = 8'h59;
  localparam logic [7:0] BCD_YEAR_MAX  = 8'h99;
  localparam logic [7:0] BCD_MONTH_MAX = 8'h12;
  localparam logic [7:0] BCD_DAY_MAX   = 8'h31;
  localparam logic [7:0] WEEKDAY_MAX   = 8'd6;

  // Days per month, January first, common year
  localparam logic [7:0] MONTH_LEN [12] = '{
    8'd31, 8'd28, 8'd31, 8'd30, 8'd31, 8'd30,
    8'd31, 8'd31, 8'd30, 8'd31, 8'd30, 8'd31
  };

  // Clock and calendar state
  typedef struct packed {
    logic [6:0] sec;
    logic [7:0] min;
    logic [7:0] hour;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year;
    logic [2:0] weekday;
  } cal_t;

  // Reset calendar
  localparam cal_t CAL_RESET = '{
    sec: 7'd0, min: 8'd0, hour: 8'd8, day: 8'd20,
    month: 8'd9, year: 8'd16, weekday: 3'd2
  };

  // True when v is a multiple of rate; compares against each multiple in range
  function automatic logic rate_hit_f(logic [8:0] v, int unsigned rate);
    logic hit;
    hit = 1'b0;
    if (rate != 0) begin
      for (int unsigned k = 0; k < 512; k++) begin
        if ((k * rate) < 512 && v == 9'(k * rate)) begin
          hit = 1'b1;
        end
      end
    end
    return hit;
  endfunction

  // Convert a BCD byte as high nibble * 10 + low nibble, nibbles unchecked
  function automatic logic [7:0] from_bcd_f(logic [7:0] b);
    return ({4'd0, b[7:4]} << 3) + ({4'd0, b[7:4]} << 1) + {4'd0, b[3:0]};
  endfunction

  // Days in the given month; months outside 1..12 count as 31 days
  function automatic logic [7:0] days_in_month_f(logic [7:0] month, logic [7:0] year);
    logic leap;
    logic [7:0] len;
    // Gregorian rule on the stored year: years 100 and 200 are not leap, 0 is
    leap = (year[1:0] == 2'b00 && year != 8'd100 && year != 8'd200) || year == 8'd0;
    if (month == 8'd0 || month > LAST_MONTH) begin
      len = 8'd31;
    end else if (month == 8'd2 && leap) begin
      len = 8'd29;
    end else begin
      len = MONTH_LEN[month[3:0] - 4'd1];
    end
    return len;
  endfunction

endpackage

/* rtl/rtcc_step.sv */
// Next-state logic of the RTC calendar: one tick or set item applied to the
// current calendar, with event flags and set error. Uses rtcc_pkg.
module rtcc_step import rtcc_pkg::*; (
  input  cal_t       cur,
  input  op_t        operation,
  input  logic [5:0] delta_seconds,
  input  logic [7:0] bcd_first,
  input  logic [7:0] bcd_middle,
  input  logic [7:0] bcd_last,
  input  logic [7:0] weekday_value,
  output cal_t       nxt,
  output logic [7:0] event_flags,
  output logic       set_error
);

  logic [8:0] sec_sum;
  logic [8:0] min_inc;
  logic [8:0] hour_inc;
  logic [8:0] day_inc;
  logic [8:0] month_inc;
  logic [7:0] month_days;
  logic [2:0] weekday_inc;
  logic [7:0] year_inc;
  logic       time_bad;
  logic       date_bad;

  // Carry chain candidates
  assign sec_sum     = {2'd0, cur.sec} + {3'd0, delta_seconds};
  assign min_inc     = {1'b0, cur.min} + 9'd1;
  assign hour_inc    = {1'b0, cur.hour} + 9'd1;
  assign day_inc     = {1'b0, cur.day} + 9'd1;
  assign month_inc   = {1'b0, cur.month} + 9'd1;
  assign month_days  = days_in_month_f(cur.month, cur.year);
  assign weekday_inc = (cur.weekday >= LAST_WEEKDAY) ? cur.weekday - LAST_WEEKDAY
                                                     : cur.weekday + 3'd1;
  assign year_inc    = (cur.year >= LAST_YEAR) ? 8'd0 : cur.year + 8'd1;

  // Range checks on raw BCD bytes
  assign time_bad = bcd_first > BCD_HOUR_MAX || bcd_middle > BCD_MINSEC_MAX ||
                    bcd_last > BCD_MINSEC_MAX;
  assign date_bad = bcd_first > BCD_YEAR_MAX || bcd_middle > BCD_MONTH_MAX ||
                    bcd_last > BCD_DAY_MAX || weekday_value > WEEKDAY_MAX;

  // Apply the item
  always_comb begin
    nxt         = cur;
    event_flags = 8'd0;
    set_error   = 1'b0;
    unique case (operation)
      OP_TICK: begin
        event_flags[FLG_WDOG]    = 1'b1;
        event_flags[FLG_SENSOR]  = rate_hit_f(sec_sum, SENSOR_RATE);
        event_flags[FLG_BATTERY] = rate_hit_f(sec_sum, BATT_RATE);
        if (sec_sum < SEC_PER_MIN) begin
          nxt.sec = sec_sum[6:0];
        end else begin
          // Minute rollover; excess seconds drop
          nxt.sec = 7'd0;
          event_flags[FLG_MINUTE]  = 1'b1;
          event_flags[FLG_CFGSAVE] = rate_hit_f(min_inc, SAVE_MINUTES);
          if (min_inc < MIN_PER_HOUR) begin
            nxt.min = min_inc[7:0];
          end else begin
            nxt.min = 8'd0;
            event_flags[FLG_HOUR]  = 1'b1;
            event_flags[FLG_CLEAR] = (hour_inc == CLEAR_HOUR);
            if (hour_inc < HOUR_PER_DAY) begin
              nxt.hour = hour_inc[7:0];
            end else begin
              // Day rollover
              event_flags[FLG_DAY] = 1'b1;
              nxt.hour    = 8'd0;
              nxt.weekday = weekday_inc;
              if (day_inc <= {1'b0, month_days}) begin
                nxt.day = day_inc[7:0];
              end else begin
                nxt.day = 8'd1;
                if (month_inc < {1'b0, LAST_MONTH} + 9'd1) begin
                  nxt.month = month_inc[7:0];
                end else begin
                  nxt.month = 8'd1;
                  nxt.year  = year_inc;
                end
              end
            end
          end
        end
      end
      OP_SET_TIME: begin
        if (time_bad) begin
          set_error = 1'b1;
        end else begin
          nxt.hour = from_bcd_f(bcd_first);
          nxt.min  = from_bcd_f(bcd_middle);
          nxt.sec  = 7'(from_bcd_f(bcd_last));
        end
      end
      OP_SET_DATE: begin
        if (date_bad) begin
          set_error = 1'b1;
        end else begin
          nxt.year    = from_bcd_f(bcd_first);
          nxt.month   = from_bcd_f(bcd_middle);
          nxt.day     = from_bcd_f(bcd_last);
          nxt.weekday = weekday_value[2:0];
        end
      end
      default: begin
        // Unused code: nothing changes
        nxt = cur;
      end
    endcase
  end

endmodule

/* rtl/rtc_calendar_tick_core.sv */
// Top level of the RTC calendar tick core: input register, calendar state,
// result register and handshakes. Uses rtcc_pkg and rtcc_step.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | operation, delta, three BCD bytes, weekday
//   out_    | output    | out_valid/out_stall| calendar fields, event flags, set error
//
// One item per cycle sustained while out_stall is low; an accepted item passes from the
// input register through the step logic into the result register.
// The calendar registers update as an item moves into the result register.
// in_stall rises only while both registers are full and out_stall is high.
// rst_n (synchronous, active low) loads the reset calendar and empties both stages.
module rtc_calendar_tick_core import rtcc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [5:0] in_delta_seconds,
  input  logic [7:0] in_bcd_first,
  input  logic [7:0] in_bcd_middle,
  input  logic [7:0] in_bcd_last,
  input  logic [7:0] in_weekday_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_second,
  output logic [7:0] out_minute,
  output logic [7:0] out_hour,
  output logic [7:0] out_day,
  output logic [7:0] out_month,
  output logic [7:0] out_year,
  output logic [2:0] out_weekday,
  output logic [7:0] out_event_flags,
  output logic       out_set_error
);

  logic       a_valid_r;
  logic [1:0] a_op_r;
  logic [5:0] a_delta_r;
  logic [7:0] a_first_r;
  logic [7:0] a_middle_r;
  logic [7:0] a_last_r;
  logic [7:0] a_wday_r;
  cal_t       cal_r;
  cal_t       cal_nxt;
  logic [7:0] flags_nxt;
  logic       err_nxt;
  logic       out_valid_r;
  cal_t       res_cal_r;
  logic [7:0] res_flags_r;
  logic       res_err_r;
  logic       in_take;
  logic       a_adv;

  // Handshake control
  assign a_adv    = a_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = a_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  // Step logic
  rtcc_step u_step (
    .cur           (cal_r),
    .operation     (op_t'(a_op_r)),
    .delta_seconds (a_delta_r),
    .bcd_first     (a_first_r),
    .bcd_middle    (a_middle_r),
    .bcd_last      (a_last_r),
    .weekday_value (a_wday_r),
    .nxt           (cal_nxt),
    .event_flags   (flags_nxt),
    .set_error     (err_nxt)
  );

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_take) begin
      a_valid_r <= 1'b1;
    end else if (a_adv) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_op_r     <= in_operation;
      a_delta_r  <= in_delta_seconds;
      a_first_r  <= in_bcd_first;
      a_middle_r <= in_bcd_middle;
      a_last_r   <= in_bcd_last;
      a_wday_r   <= in_weekday_value;
    end
  end

  // Advance the calendar and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r       <= CAL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (a_adv) begin
        cal_r       <= cal_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      res_cal_r   <= cal_nxt;
      res_flags_r <= flags_nxt;
      res_err_r   <= err_nxt;
    end
  end

  // Drive result ports
  assign out_valid       = out_valid_r;
  assign out_second      = res_cal_r.sec;
  assign out_minute      = res_cal_r.min;
  assign out_hour        = res_cal_r.hour;
  assign out_day         = res_cal_r.day;
  assign out_month       = res_cal_r.month;
  assign out_year        = res_cal_r.year;
  assign out_weekday     = res_cal_r.weekday;
  assign out_event_flags = res_flags_r;
  assign out_set_error   = res_err_r;

endmodule
